/* src/sorted_list_insert_remove_core_assert.svh */
// assertion macros shared by the sorted table core
`ifndef SORTED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH

// clocked check, held off while reset is asserted
`define SLIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds through reset
`define SLIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/slir_pkg.sv */
// types and constants of the sorted table core
package slir_pkg;

  // default sizes
  localparam int unsigned DefTableDepth = 64;
  localparam int unsigned DefValueWidth = 32;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INS_RD  = 9'b000000010,
    S_INS_CMP = 9'b000000100,
    S_INS_PUT = 9'b000001000,
    S_REM_RD  = 9'b000010000,
    S_REM_CMP = 9'b000100000,
    S_SHF_RD  = 9'b001000000,
    S_SHF_WR  = 9'b010000000,
    S_RESP    = 9'b100000000
  } state_e;

endpackage

/* src/slir_in_if.sv */
// input channel: operation kind and value
interface slir_in_if #(
  parameter int unsigned ValueWidth = 32
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [ValueWidth-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

/* src/slir_out_if.sv */
// output channel: status, entry count and empty flag
interface slir_out_if #(
  parameter int unsigned CountWidth = 7
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [CountWidth-1:0] entry_count;
  logic                  is_empty;

  modport source (output valid, output status, output entry_count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input is_empty,
                  output ready);
endinterface

/* src/slir_ram.sv */
// simple dual-port table memory with registered read
module slir_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sorted_list_insert_remove_core.sv */
// Sorted table core: keeps up to TableDepth signed values in ascending order in a
// single memory and serves one insert or remove per item with a small sequencer around
// one comparator. A result still held at the output keeps the sequencer waiting in
// its response state. An insert walks down from the top, moving each larger entry up
// one place. A remove scans up from the bottom for the first equal entry, then moves
// the entries above it down (an absent value scans the whole table). Every table read
// takes its own state before the compare or write state that uses it, because the
// table read is registered. A full-table insert or an empty-table remove goes straight
// to the response state. A new item is taken while the previous result still waits in
// the output register.
module sorted_list_insert_remove_core
  import slir_pkg::*;
#(
  parameter int unsigned TableDepth = DefTableDepth,
  parameter int unsigned ValueWidth = DefValueWidth,
  localparam int unsigned IdxW = $clog2(TableDepth),
  localparam int unsigned CntW = $clog2(TableDepth + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slir_in_if.sink    in_i,
  slir_out_if.source out_o
);

  `include "sorted_list_insert_remove_core_assert.svh"

  state_e                       state_q, state_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic [CntW-1:0]              count_q, count_d;
  status_e                      stat_q, stat_d;
  logic signed [ValueWidth-1:0] val_q, val_d;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [CntW-1:0]       out_count_q;
  logic                  out_empty_q;
  logic                  out_load;

  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [ValueWidth-1:0] mem_wdata;
  logic [IdxW-1:0]       mem_raddr;
  logic [ValueWidth-1:0] mem_rdata;

  logic signed [ValueWidth-1:0] rd_val;
  logic                         rd_gt;
  logic                         rd_eq;
  logic                         scan_last;
  logic                         shift_last;

  // table storage
  slir_ram #(
    .Depth (TableDepth),
    .Width (ValueWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // shared comparator against the item value
  assign rd_val = $signed(mem_rdata);
  assign rd_gt  = rd_val > val_q;
  assign rd_eq  = rd_val == val_q;

  // end-of-table tests for the remove scan and the shift down
  assign scan_last  = (CntW'(idx_q) + CntW'(1)) == count_q;
  assign shift_last = (CntW'(idx_q) + CntW'(2)) == count_q;

  // read address: below the slot on insert, above it on shift
  always_comb begin
    case (state_q)
      S_INS_RD: mem_raddr = idx_q - IdxW'(1);
      S_SHF_RD: mem_raddr = idx_q + IdxW'(1);
      default:  mem_raddr = idx_q;
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    stat_d    = stat_q;
    val_d     = val_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = mem_rdata;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          val_d = in_i.value;
          if (in_i.kind == KIND_INSERT) begin
            if (count_q == CntW'(TableDepth)) begin
              stat_d  = ST_FULL;
              state_d = S_RESP;
            end else begin
              idx_d   = count_q[IdxW-1:0];
              state_d = (count_q == '0) ? S_INS_PUT : S_INS_RD;
            end
          end else begin
            if (count_q == '0) begin
              stat_d  = ST_NOT_FOUND;
              state_d = S_RESP;
            end else begin
              idx_d   = '0;
              state_d = S_REM_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (rd_gt) begin
          mem_we  = 1'b1;
          idx_d   = idx_q - IdxW'(1);
          state_d = (idx_q == IdxW'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = val_q;
        count_d   = count_q + CntW'(1);
        stat_d    = ST_DONE;
        state_d   = S_RESP;
      end
      S_REM_RD: begin
        state_d = S_REM_CMP;
      end
      S_REM_CMP: begin
        if (rd_eq) begin
          if (scan_last) begin
            count_d = count_q - CntW'(1);
            stat_d  = ST_DONE;
            state_d = S_RESP;
          end else begin
            state_d = S_SHF_RD;
          end
        end else if (scan_last) begin
          stat_d  = ST_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_REM_RD;
        end
      end
      S_SHF_RD: begin
        state_d = S_SHF_WR;
      end
      S_SHF_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + IdxW'(1);
        if (shift_last) begin
          count_d = count_q - CntW'(1);
          stat_d  = ST_DONE;
          state_d = S_RESP;
        end else begin
          state_d = S_SHF_RD;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      stat_q      <= ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      stat_q  <= stat_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (out_load) begin
      out_status_q <= stat_q;
      out_count_q  <= count_q;
      out_empty_q  <= (count_q == '0);
    end
  end

  // result beat
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.is_empty    = out_empty_q;

  // checks
  `SLIR_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(TableDepth), "entry count above depth")
  `SLIR_ASSERT(a_write_in_range,
    mem_we |-> (CntW'(mem_waddr) <= count_q),
    "table write above count")
  `SLIR_ASSERT(a_full_status,
    (out_valid_q && out_status_q == ST_FULL) |-> (out_count_q == CntW'(TableDepth)),
    "full status with room left")
  `SLIR_ASSERT(a_count_moves,
    (count_q != $past(count_q)) |-> ($past(state_q) == S_INS_PUT ||
      $past(state_q) == S_REM_CMP || $past(state_q) == S_SHF_WR),
    "count changed outside update")

endmodule

/* tb/sorted_list_insert_remove_core_tb.sv */
// testbench for the sorted table core: directed table, then random insert/remove traffic
`timescale 1ns / 100ps

module sorted_list_insert_remove_core_tb;
  import slir_pkg::*;

  localparam int unsigned Depth      = 64;
  localparam int unsigned VW         = 32;
  localparam int unsigned CW         = 7;
  localparam int unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    status_e       status;
    logic [CW-1:0] entry_count;
    logic          is_empty;
  } table_reply_t;

  typedef struct {
    logic                 kind;
    logic signed [VW-1:0] value;
    bit                   typed;
    table_reply_t         reply;
  } stim_row_t;

  typedef enum {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  slir_in_if  #(.ValueWidth(VW)) in_if ();
  slir_out_if #(.CountWidth(CW)) out_if ();

  sorted_list_insert_remove_core #(
    .TableDepth(Depth),
    .ValueWidth(VW)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // own copy of the sorted table
  logic signed [VW-1:0] shadow_vals [Depth];
  int unsigned          shadow_count;

  table_reply_t pending_replies [$];
  int unsigned  err_cnt;
  int unsigned  cycle_cnt;
  bit           quiet_phase;

  // insert after equal values, or remove first equal value, and return the reply
  function automatic table_reply_t apply_to_shadow(logic kind, logic signed [VW-1:0] value);
    table_reply_t r;
    int unsigned  pos;
    pos = 0;
    r.status = ST_DONE;
    if (kind == KIND_INSERT) begin
      if (shadow_count >= Depth) begin
        r.status = ST_FULL;
      end else begin
        while (pos < shadow_count && shadow_vals[pos] <= value) pos++;
        for (int unsigned i = shadow_count; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[pos] = value;
        shadow_count++;
      end
    end else begin
      while (pos < shadow_count && shadow_vals[pos] != value) pos++;
      if (pos >= shadow_count) begin
        r.status = ST_NOT_FOUND;
      end else begin
        for (int unsigned i = pos; i + 1 < shadow_count; i++) shadow_vals[i] = shadow_vals[i+1];
        shadow_count--;
      end
    end
    r.entry_count = shadow_count[CW-1:0];
    r.is_empty    = (shadow_count == 0);
    return r;
  endfunction

  // value mix: small pool for duplicates and hits, extremes, and full-range values
  function automatic logic signed [VW-1:0] pick_value(bit from_table);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (from_table && shadow_count > 0 && roll < 6)
      return shadow_vals[$urandom_range(0, shadow_count - 1)];
    roll = $urandom_range(0, 9);
    if (roll < 4) return $signed($urandom_range(0, 8)) - 4;
    if (roll == 4) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(VW-1){1'b0}}};
        1: return {1'b0, {(VW-1){1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic report_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // one input beat, with a random lead-in gap outside quiet phases
  task automatic send_item(logic kind, logic signed [VW-1:0] value);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.value <= value;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // cycle watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls outside quiet phases, compare each beat with the oldest pending reply
  initial begin
    table_reply_t want;
    int unsigned  stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (pending_replies.size() == 0) begin
        $error("result beat with no pending reply");
        err_cnt++;
      end else begin
        want = pending_replies.pop_front();
        report_field("status", want.status, out_if.status);
        report_field("entry_count", want.entry_count, out_if.entry_count);
        report_field("is_empty", want.is_empty, out_if.is_empty);
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t    rows [$];
    table_reply_t got;
    traffic_mix_e mix;
    int unsigned  n_items;
    int unsigned  ins_pct;
    logic         kind;
    logic signed [VW-1:0] vmin;
    logic signed [VW-1:0] vmax;

    vmin = {1'b1, {(VW-1){1'b0}}};
    vmax = {1'b0, {(VW-1){1'b1}}};
    err_cnt      = 0;
    shadow_count = 0;
    quiet_phase  = 1'b0;

    in_if.valid <= 1'b0;
    in_if.kind  <= KIND_INSERT;
    in_if.value <= '0;
    rst_ni      <= 1'b0;

    // directed rows: typed replies where obvious, the rest from the shadow table
    rows.push_back('{KIND_REMOVE, 0,    1, '{ST_NOT_FOUND, 7'd0, 1'b1}});
    rows.push_back('{KIND_INSERT, vmin, 1, '{ST_DONE,      7'd1, 1'b0}});
    rows.push_back('{KIND_REMOVE, vmax, 1, '{ST_NOT_FOUND, 7'd1, 1'b0}});
    rows.push_back('{KIND_INSERT, vmax, 1, '{ST_DONE,      7'd2, 1'b0}});
    rows.push_back('{KIND_INSERT, 0,    0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_INSERT, -1,   0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_INSERT, vmin, 0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_INSERT, vmax, 0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_INSERT, 0,    0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_INSERT, 1,    0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_REMOVE, 0,    0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_REMOVE, 5,    0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_REMOVE, vmin, 0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_REMOVE, vmin, 0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_REMOVE, vmin, 0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_REMOVE, vmax, 0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_REMOVE, 1,    0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_REMOVE, vmax, 0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_REMOVE, -1,   0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_REMOVE, 0,    0, '{ST_DONE, 7'd0, 1'b0}});
    rows.push_back('{KIND_REMOVE, 0,    1, '{ST_NOT_FOUND, 7'd0, 1'b1}});

    // reset
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (rows[i]) begin
      send_item(rows[i].kind, rows[i].value);
      got = apply_to_shadow(rows[i].kind, rows[i].value);
      pending_replies.push_back(rows[i].typed ? rows[i].reply : got);
    end

    // random part: first block fills past full, later blocks fill, drain or mix
    for (int blk = 0; blk < 25; blk++) begin
      mix         = (blk == 0) ? MIX_FILL : traffic_mix_e'($urandom_range(0, 2));
      quiet_phase = ($urandom_range(0, 3) == 0);
      n_items     = (blk == 0) ? 72 : 62;
      case (mix)
        MIX_FILL:  ins_pct = (blk == 0) ? 100 : 85;
        MIX_DRAIN: ins_pct = 12;
        default:   ins_pct = 50;
      endcase
      for (int unsigned k = 0; k < n_items; k++) begin
        logic signed [VW-1:0] v;
        kind = ($urandom_range(1, 100) <= ins_pct) ? KIND_INSERT : KIND_REMOVE;
        v    = pick_value(kind == KIND_REMOVE);
        send_item(kind, v);
        pending_replies.push_back(apply_to_shadow(kind, v));
      end
    end
    in_if.valid <= 1'b0;
    quiet_phase = 1'b0;

    // drain the pending replies, then let the block settle
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/slir_pkg.sv
src/slir_in_if.sv
src/slir_out_if.sv
src/slir_ram.sv
src/sorted_list_insert_remove_core.sv
tb/sorted_list_insert_remove_core_tb.sv
